@@ rtl/pm4rw_pkg.sv @@
// ----------------------------------------------------------------------------
// pm4rw_pkg
// Shared types and constants for the command stream register write tracker.
// ----------------------------------------------------------------------------
package pm4rw_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned IndexW = 15;
    localparam int unsigned CountW = 14;
    localparam int unsigned Reg0W  = 13;
    localparam int unsigned Reg1W  = 11;

    typedef enum logic [1:0] {
        PKT_TYPE0 = 2'd0,
        PKT_TYPE1 = 2'd1,
        PKT_TYPE2 = 2'd2,
        PKT_TYPE3 = 2'd3
    } t_pkt_type;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_TYPE0  = 4'b0010,
        PH_TYPE1  = 4'b0100,
        PH_SKIP   = 4'b1000
    } t_phase;

    localparam logic [IndexW-1:0] Type1Words = IndexW'(2);

    typedef struct packed {
        logic              valid;
        logic [IndexW-1:0] index;
        logic [WordW-1:0]  value;
    } t_result;

endpackage

@@ rtl/pm4rw_if.sv @@
// ----------------------------------------------------------------------------
// pm4rw_if
// Valid/ready channels for command words and register write reports.
// ----------------------------------------------------------------------------
interface pm4rw_cmd_if;
    import pm4rw_pkg::*;

    logic             valid;
    logic             ready;
    logic [WordW-1:0] command_word;
    logic             last_in_buffer;

    modport source (output valid, output command_word, output last_in_buffer, input ready);
    modport sink   (input valid, input command_word, input last_in_buffer, output ready);
endinterface

interface pm4rw_wr_if;
    import pm4rw_pkg::*;

    logic              valid;
    logic              ready;
    logic [IndexW-1:0] reg_index;
    logic [WordW-1:0]  reg_value;

    modport source (output valid, output reg_index, output reg_value, input ready);
    modport sink   (input valid, input reg_index, input reg_value, output ready);
endinterface

@@ rtl/pm4_register_write_tracker_core.sv @@
// ----------------------------------------------------------------------------
// pm4_register_write_tracker_core
// Parses a command word stream and reports each register write it implies.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                          Per request
//  i_cmd    in   command_word, last_in_buffer     one command word
//  o_wr     out  reg_index, reg_value             zero or one write report
//
// One command word is taken every cycle while the report channel does not stall;
// a write report is offered once its word has moved from the input register into
// the result register.
// Reset clears the parse state and both stage valids.
// A stalled report holds the result register; one more word may wait in the
// input register, after which the command channel stalls.
// ----------------------------------------------------------------------------
module pm4_register_write_tracker_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pm4rw_cmd_if.sink  i_cmd,
    pm4rw_wr_if.source o_wr
);
    import pm4rw_pkg::*;

    logic              r_in_valid;
    logic [WordW-1:0]  r_in_word;
    logic              r_in_last;
    logic              r_out_valid;
    logic [IndexW-1:0] r_out_index;
    logic [WordW-1:0]  r_out_value;
    logic              advance;
    t_result           result;

    assign advance     = r_in_valid && (!r_out_valid || o_wr.ready);
    assign i_cmd.ready = !r_in_valid || advance;

    pm4rw_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_word   (r_in_word),
        .i_last   (r_in_last),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_out_valid <= result.valid;
            end else if (o_wr.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_word <= i_cmd.command_word;
            r_in_last <= i_cmd.last_in_buffer;
        end
        if (advance) begin
            r_out_index <= result.index;
            r_out_value <= result.value;
        end
    end

    assign o_wr.valid     = r_out_valid;
    assign o_wr.reg_index = r_out_index;
    assign o_wr.reg_value = r_out_value;

endmodule

@@ rtl/pm4rw_parser.sv @@
// ----------------------------------------------------------------------------
// pm4rw_parser
// Packet parse state and the decode of one registered command word.
// ----------------------------------------------------------------------------
module pm4rw_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [pm4rw_pkg::WordW-1:0] i_word,
    input  logic                       i_last,
    output pm4rw_pkg::t_result         o_result
);
    import pm4rw_pkg::*;

    t_phase              r_phase,  n_phase;
    logic [IndexW-1:0]   r_remain, n_remain;
    logic [IndexW-1:0]   r_cur,    n_cur;
    logic                r_hold,   n_hold;
    logic [Reg1W-1:0]    r_second, n_second;
    logic [IndexW-1:0]   remain_dec;
    logic [IndexW-1:0]   count_p1;

    assign remain_dec = r_remain - IndexW'(1);
    assign count_p1   = IndexW'(i_word[29:16]) + IndexW'(1);

    always_comb begin
        n_phase  = r_phase;
        n_remain = r_remain;
        n_cur    = r_cur;
        n_hold   = r_hold;
        n_second = r_second;
        o_result = '{valid: 1'b0, index: r_cur, value: i_word};
        case (r_phase)
            PH_HEADER: begin
                case (t_pkt_type'(i_word[31:30]))
                    PKT_TYPE0: begin
                        n_phase  = PH_TYPE0;
                        n_remain = count_p1;
                        n_cur    = IndexW'(i_word[Reg0W-1:0]);
                        n_hold   = i_word[15];
                    end
                    PKT_TYPE1: begin
                        n_phase  = PH_TYPE1;
                        n_remain = Type1Words;
                        n_cur    = IndexW'(i_word[Reg1W-1:0]);
                        n_second = i_word[2*Reg1W-1:Reg1W];
                    end
                    PKT_TYPE3: begin
                        n_phase  = PH_SKIP;
                        n_remain = count_p1;
                    end
                    default: begin
                    end
                endcase
            end
            PH_TYPE0: begin
                o_result.valid = 1'b1;
                if (!r_hold) begin
                    n_cur = r_cur + IndexW'(1);
                end
                n_remain = remain_dec;
            end
            PH_TYPE1: begin
                o_result.valid = 1'b1;
                if (r_remain != Type1Words) begin
                    o_result.index = IndexW'(r_second);
                end
                n_remain = remain_dec;
            end
            default: begin
                n_remain = remain_dec;
            end
        endcase
        if (i_last || (r_phase != PH_HEADER && remain_dec == '0)) begin
            n_phase  = PH_HEADER;
            n_remain = '0;
            n_cur    = '0;
            n_hold   = 1'b0;
            n_second = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_remain <= '0;
            r_cur    <= '0;
            r_hold   <= 1'b0;
            r_second <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_cur    <= n_cur;
            r_hold   <= n_hold;
            r_second <= n_second;
        end
    end

endmodule

@@ rtl/pm4rw_checker.sv @@
// ----------------------------------------------------------------------------
// pm4rw_checker
// Port level checks on the register write tracker.
// ----------------------------------------------------------------------------
module pm4rw_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cmd_valid,
    input logic                         i_cmd_ready,
    input logic                         i_wr_valid,
    input logic                         i_wr_ready,
    input logic [pm4rw_pkg::IndexW-1:0] i_wr_index,
    input logic [pm4rw_pkg::WordW-1:0]  i_wr_value
);
    import pm4rw_pkg::*;

    logic cmd_take;

    assign cmd_take = i_cmd_valid && i_cmd_ready;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_wr_valid)
        else $error("Write report valid after reset.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_wr_valid |-> i_cmd_ready)
        else $error("Command channel stalled with no report pending.");

    a_report_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_wr_valid) |-> $past(cmd_take, 2))
        else $error("Write report without a command request two cycles earlier.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_valid && !i_wr_ready |=>
            i_wr_valid && $stable(i_wr_index) && $stable(i_wr_value))
        else $error("Stalled write report changed.");

endmodule

bind pm4_register_write_tracker_core pm4rw_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_wr_valid  (o_wr.valid),
    .i_wr_ready  (o_wr.ready),
    .i_wr_index  (o_wr.reg_index),
    .i_wr_value  (o_wr.reg_value)
);
